/* hdl/r2p_pkg.sv */
// Shared constants, types and the arctangent table of the rectangular-to-polar converter.
package r2p_pkg;

  // Widths of the input fields and of the result fields
  localparam int DATA_WIDTH = 16;
  localparam int MAG_W      = 16;
  localparam int PHASE_W    = 16;

  // Micro-rotation count; the arctangent table holds 24 entries
  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NUM_STAGES = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  // Datapath formats: x and y carry 16 guard bits, z is Q30 radians
  localparam int GUARD_BITS = 16;
  localparam int XY_W       = DATA_WIDTH + GUARD_BITS + 3;
  localparam int Z_W        = 34;
  localparam int ATAN_W     = 30;

  // Gain compensation constant (0.60725293 in Q30) and product widths
  localparam int                GAIN_W    = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30  = 30'd652032874;
  localparam int                HI_W      = XY_W - GUARD_BITS;
  localparam int                PHI_W     = HI_W + GAIN_W;
  localparam int                PLO_W     = GAIN_W;
  localparam int                PSUM_W    = PHI_W + 2;

  // Pi in Q30 radians and the phase clamp in Q2.13
  localparam logic signed [Z_W-1:0]     PI_Q30      = 34'sd3373259426;
  localparam logic signed [PHASE_W-1:0] PHASE_LIMIT = 16'sd25736;
  localparam logic [MAG_W-1:0]          MAG_MAX     = '1;

  // Number of registers from an accepted item to its result strobe
  localparam int LATENCY = NUM_STAGES + 3;

  // One item as it travels down the rotation pipeline
  typedef struct packed {
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [Z_W-1:0]  z;
    logic signed [XY_W-1:0] y;
  } vec_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [ATAN_W-1:0] atan_q30(input int idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      0:       val = 30'd843314856;
      1:       val = 30'd497837829;
      2:       val = 30'd263043836;
      3:       val = 30'd133525158;
      4:       val = 30'd67021686;
      5:       val = 30'd33543515;
      6:       val = 30'd16775850;
      7:       val = 30'd8388437;
      8:       val = 30'd4194282;
      9:       val = 30'd2097149;
      10:      val = 30'd1048575;
      11:      val = 30'd524287;
      12:      val = 30'd262143;
      13:      val = 30'd131071;
      14:      val = 30'd65535;
      15:      val = 30'd32767;
      16:      val = 30'd16383;
      17:      val = 30'd8191;
      18:      val = 30'd4095;
      19:      val = 30'd2047;
      20:      val = 30'd1023;
      21:      val = 30'd511;
      22:      val = 30'd255;
      23:      val = 30'd127;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* hdl/r2p_prerot.sv */
// Input stage: zero detect and half-plane pre-rotation into the right half plane.
module r2p_prerot (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vld_i,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] real_part_i,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] imag_part_i,
  output logic                                 vld_o,
  output r2p_pkg::vec_t                        vec_o
);
  import r2p_pkg::*;

  logic                   vld_q;
  vec_t                   vec_d, vec_q;
  logic signed [XY_W-1:0] re_s, im_s;

  // Scale the inputs onto the guard-bit grid
  assign re_s = XY_W'(real_part_i) <<< GUARD_BITS;
  assign im_s = XY_W'(imag_part_i) <<< GUARD_BITS;

  // Rotate a left-half-plane vector by pi and seed the angle accordingly
  always_comb begin
    vec_d.zero = (real_part_i == '0) && (imag_part_i == '0);
    if (real_part_i < 0) begin
      vec_d.x = -re_s;
      vec_d.y = -im_s;
      vec_d.z = (imag_part_i >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      vec_d.x = re_s;
      vec_d.y = im_s;
      vec_d.z = '0;
    end
  end

  // Hold the valid bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Advance the payload every cycle
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vld_o = vld_q;
  assign vec_o = vec_q;

endmodule

/* hdl/r2p_cordic_core.sv */
// Unrolled CORDIC vectoring pipeline: one micro-rotation per register stage.
module r2p_cordic_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  r2p_pkg::vec_t vec_i,
  output logic          vld_o,
  output r2p_pkg::vec_t vec_o
);
  import r2p_pkg::*;

  logic vld_q [NUM_STAGES];
  vec_t vec_q [NUM_STAGES];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    logic                   cur_vld;
    vec_t                   cur, nxt;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;

    // Pick up the item from the previous stage
    if (g == 0) begin : g_first
      assign cur_vld = vld_i;
      assign cur     = vec_i;
    end else begin : g_next
      assign cur_vld = vld_q[g-1];
      assign cur     = vec_q[g-1];
    end

    // Rotate toward the x axis by atan(2^-g)
    assign xs  = cur.x >>> g;
    assign ys  = cur.y >>> g;
    assign ang = Z_W'(atan_q30(g));

    always_comb begin
      nxt.zero = cur.zero;
      if (cur.y >= 0) begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + ang;
      end else begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      vec_q[g] <= nxt;
    end
  end

  assign vld_o = vld_q[NUM_STAGES-1];
  assign vec_o = vec_q[NUM_STAGES-1];

endmodule

/* hdl/r2p_post.sv */
// Output stages: gain compensation, rounding, saturation and phase clamp.
module r2p_post (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  vld_i,
  input  r2p_pkg::vec_t                         vec_i,
  output logic                                  done_o,
  output logic [r2p_pkg::MAG_W-1:0]             magnitude_o,
  output logic signed [r2p_pkg::PHASE_W-1:0]    phase_o,
  output logic                                  zero_input_o
);
  import r2p_pkg::*;

  localparam int PH_W = Z_W + 1 - 17;

  // First stage: split the product and round the angle
  logic [XY_W-1:0]        ux;
  logic [PHI_W-1:0]       phi_d, phi_q;
  logic [PLO_W-1:0]       plo_d, plo_q;
  logic [GUARD_BITS+GAIN_W-1:0] plo_full;
  logic signed [Z_W:0]    zr;
  logic signed [PH_W-1:0] ph_d, ph_q;
  logic                   zero_q, vld_q;

  assign ux       = vec_i.x;
  assign phi_d    = PHI_W'(ux[XY_W-1:GUARD_BITS]) * PHI_W'(GAIN_Q30);
  assign plo_full = (GUARD_BITS+GAIN_W)'(ux[GUARD_BITS-1:0]) * (GUARD_BITS+GAIN_W)'(GAIN_Q30);
  assign plo_d    = plo_full[GUARD_BITS+GAIN_W-1:GUARD_BITS];
  assign zr       = (Z_W+1)'(vec_i.z) + (Z_W+1)'(1 <<< 16);
  assign ph_d     = PH_W'(zr >>> 17);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    phi_q  <= phi_d;
    plo_q  <= plo_d;
    ph_q   <= ph_d;
    zero_q <= vec_i.zero;
  end

  // Second stage: sum, round half up, saturate, clamp, force zero input
  logic [PSUM_W-1:0]        psum;
  logic [PSUM_W-31:0]       mag_full;
  logic [MAG_W-1:0]         mag_d, mag_q;
  logic signed [PHASE_W-1:0] phs_d, phs_q;
  logic                      done_q, zflag_q;

  assign psum     = PSUM_W'(phi_q) + PSUM_W'(plo_q) + PSUM_W'(1 << 29);
  assign mag_full = psum[PSUM_W-1:30];

  always_comb begin
    if (zero_q) begin
      mag_d = '0;
      phs_d = '0;
    end else begin
      if (mag_full > (PSUM_W-30)'(MAG_MAX)) begin
        mag_d = MAG_MAX;
      end else begin
        mag_d = mag_full[MAG_W-1:0];
      end
      if (ph_q > PH_W'(PHASE_LIMIT)) begin
        phs_d = PHASE_LIMIT;
      end else if (ph_q < -PH_W'(PHASE_LIMIT)) begin
        phs_d = -PHASE_LIMIT;
      end else begin
        phs_d = ph_q[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    phs_q   <= phs_d;
    zflag_q <= zero_q;
  end

  assign done_o       = done_q;
  assign magnitude_o  = mag_q;
  assign phase_o      = phs_q;
  assign zero_input_o = zflag_q;

endmodule

/* hdl/rect_to_polar_converter.sv */
// Top level of the pipelined CORDIC rectangular-to-polar converter.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | start, busy            | real_part_i, imag_part_i (signed Q7.8)
//  result   | done_o (one-cycle)     | magnitude_o (unsigned Q8.8), phase_o (Q2.13),
//           |                        | zero_input_o
//
// One item is taken every cycle; busy stays low. Each result passes through
// one pre-rotation stage, one stage per micro-rotation and two gain/rounding
// stages on its way from the item to done_o.
// Reset clears only the valid bits; items in flight at reset are dropped.
// Results are shown for exactly one cycle on done_o; nothing stalls.
module rect_to_polar_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] real_part_i,
  input  logic signed [r2p_pkg::DATA_WIDTH-1:0] imag_part_i,
  output logic                                 done_o,
  output logic [r2p_pkg::MAG_W-1:0]            magnitude_o,
  output logic signed [r2p_pkg::PHASE_W-1:0]   phase_o,
  output logic                                 zero_input_o
);
  import r2p_pkg::*;

  logic accept;
  logic pre_vld, core_vld;
  vec_t pre_vec, core_vec;

  // Accept an item in every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  r2p_prerot u_prerot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .vld_o       (pre_vld),
    .vec_o       (pre_vec)
  );

  r2p_cordic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pre_vld),
    .vec_i  (pre_vec),
    .vld_o  (core_vld),
    .vec_o  (core_vec)
  );

  r2p_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (core_vld),
    .vec_i        (core_vec),
    .done_o       (done_o),
    .magnitude_o  (magnitude_o),
    .phase_o      (phase_o),
    .zero_input_o (zero_input_o)
  );

  // Every accepted item shows up after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LATENCY) done_o)
    else $error("result strobe missing after pipeline latency");

  // A zero input gives zero magnitude and zero phase
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_input_o) |-> (magnitude_o == '0 && phase_o == '0))
    else $error("zero input result not forced to zero");

  // Phase stays within minus pi to pi
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (phase_o <= PHASE_LIMIT && phase_o >= -PHASE_LIMIT))
    else $error("phase out of range");

endmodule
